### sv/assert_macros.svh
// Assertion macros shared by the RTL of the event log.
// Define ASSERT_OFF to compile every assertion out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### sv/orel_pkg.sv
// ----------------------------------------------------------------------------
// orel_pkg
// Shared types and constants of the overwrite-oldest event log.
// ----------------------------------------------------------------------------
package orel_pkg;

    localparam int DEF_LOG_DEPTH    = 64;
    localparam int DEF_PAYLOAD_BITS = 64;

    localparam int OPCODE_W  = 1;
    localparam int PAYLOAD_W = 64;
    localparam int POS_W     = 6;
    localparam int STATUS_W  = 2;
    localparam int STAMP_W   = 64;
    localparam int COUNT_W   = 7;
    localparam int DENIED_W  = 32;

    localparam logic [OPCODE_W-1:0] OP_APPEND = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_READ   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // Control of the entry memory for one access.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctrl;

endpackage

### sv/orel_ring.sv
// ----------------------------------------------------------------------------
// orel_ring
// Entry memory of the event log: one synchronous port, registered read data.
// ----------------------------------------------------------------------------
module orel_ring #(
    parameter int DEPTH = orel_pkg::DEF_LOG_DEPTH,
    parameter int WIDTH = orel_pkg::DEF_PAYLOAD_BITS + 1 + orel_pkg::STAMP_W
) (
    input  logic                     i_clk,
    input  orel_pkg::t_mem_ctrl      i_ctrl,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    output logic [WIDTH-1:0]         o_rd_data
);
    import orel_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/overwrite_ring_event_log.sv
// ----------------------------------------------------------------------------
// overwrite_ring_event_log
// Bounded chronological event log that overwrites its oldest entry when full.
// ----------------------------------------------------------------------------
//  Channel | Valid       | Stall       | Words
//  --------+-------------+-------------+------------------------------------
//  input   | i_in_valid  | o_in_stall  | opcode, payload, allowed, action
//  output  | o_out_valid | i_out_stall | status, entry, count, denied total
//
//  One word is accepted per cycle while o_in_stall is low; its result passes
//  through the registered read of the entry memory and then the output register.
//  Head, count, stamp and denied total update on the accepting edge, so the
//  next word sees them at once and no forwarding is needed.
//  Reset clears the control state and starts the stamp at one; the entry
//  memory is not cleared, as only written entries can be reached.
//  A stalled output holds its word; o_in_stall rises when both stages are full
//  and the output is stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module overwrite_ring_event_log #(
    parameter int LOG_DEPTH    = orel_pkg::DEF_LOG_DEPTH,
    parameter int PAYLOAD_BITS = orel_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [orel_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [orel_pkg::PAYLOAD_W-1:0] i_payload,
    input  logic                           i_allowed,
    input  logic                           i_action_empty,
    input  logic [orel_pkg::POS_W-1:0]     i_read_position,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [orel_pkg::STATUS_W-1:0]  o_status,
    output logic [orel_pkg::PAYLOAD_W-1:0] o_read_payload,
    output logic                           o_read_allowed,
    output logic [orel_pkg::STAMP_W-1:0]   o_read_sequence,
    output logic [orel_pkg::COUNT_W-1:0]   o_entry_count,
    output logic [orel_pkg::DENIED_W-1:0]  o_denied_total
);
    import orel_pkg::*;

    localparam int AW = $clog2(LOG_DEPTH);
    localparam int CW = $clog2(LOG_DEPTH + 1);
    localparam int MW = (CW > POS_W) ? CW : POS_W;
    localparam int SW = ((AW > POS_W) ? AW : POS_W) + 1;
    localparam int DW = PAYLOAD_BITS + 1 + STAMP_W;

    // Control state
    logic [AW-1:0]       r_oldest,  n_oldest;
    logic [CW-1:0]       r_held,    n_held;
    logic [STAMP_W-1:0]  r_stamp,   n_stamp;
    logic [DENIED_W-1:0] r_denied,  n_denied;

    // Stage waiting for the memory read
    logic                r_s1_valid;
    t_status             r_s1_status;
    logic                r_s1_hit;
    logic [CW-1:0]       r_s1_count;
    logic [DENIED_W-1:0] r_s1_denied;

    // Output register
    logic                r_out_valid;
    t_status             r_out_status;
    logic [PAYLOAD_W-1:0] r_out_payload;
    logic                r_out_allowed;
    logic [STAMP_W-1:0]  r_out_seq;
    logic [COUNT_W-1:0]  r_out_count;
    logic [DENIED_W-1:0] r_out_denied;

    logic                s1_move;
    logic                accept;
    logic                is_read;
    logic                do_append;
    logic                full;
    logic                read_hit;
    logic [AW-1:0]       app_slot;
    logic [AW-1:0]       rd_slot;
    t_status             n_status;
    t_mem_ctrl           mem_ctrl;
    logic [AW-1:0]       mem_addr;
    logic [DW-1:0]       mem_wr_data;
    logic [DW-1:0]       mem_rd_data;

    function automatic logic [AW-1:0] wrap_slot(input logic [SW-1:0] sum);
        logic [SW-1:0] lim;
        lim = SW'(LOG_DEPTH);
        if (sum >= lim) begin
            return AW'(sum - lim);
        end
        return AW'(sum);
    endfunction

    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_move;
    assign accept     = i_in_valid && !o_in_stall;
    assign is_read    = (i_opcode == OP_READ);
    assign do_append  = accept && (i_opcode == OP_APPEND) && !i_action_empty;
    assign full       = (r_held == CW'(LOG_DEPTH));
    assign read_hit   = (MW'(i_read_position) < MW'(r_held));

    // Below full the new entry goes after the newest; when full it replaces the oldest.
    assign app_slot = full ? r_oldest : wrap_slot(SW'(r_oldest) + SW'(r_held));
    assign rd_slot  = wrap_slot(SW'(r_oldest) + SW'(i_read_position));

    always_comb begin
        n_oldest = r_oldest;
        n_held   = r_held;
        n_stamp  = r_stamp;
        n_denied = r_denied;
        if (do_append) begin
            if (!full) begin
                n_held = r_held + 1'b1;
            end else if (r_oldest == AW'(LOG_DEPTH - 1)) begin
                n_oldest = '0;
            end else begin
                n_oldest = r_oldest + 1'b1;
            end
            n_stamp = r_stamp + 1'b1;
            if (!i_allowed && (r_denied != '1)) begin
                n_denied = r_denied + 1'b1;
            end
        end
    end

    always_comb begin
        if (is_read) begin
            n_status = read_hit ? ST_OK : ST_NOT_FOUND;
        end else begin
            n_status = i_action_empty ? ST_INVALID : ST_OK;
        end
    end

    assign mem_ctrl.wr_en = do_append;
    assign mem_ctrl.rd_en = accept && is_read && read_hit;
    assign mem_addr       = is_read ? rd_slot : app_slot;
    assign mem_wr_data    = {r_stamp, i_allowed, i_payload[PAYLOAD_BITS-1:0]};

    orel_ring #(
        .DEPTH (LOG_DEPTH),
        .WIDTH (DW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_ctrl    (mem_ctrl),
        .i_addr    (mem_addr),
        .i_wr_data (mem_wr_data),
        .o_rd_data (mem_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest    <= '0;
            r_held      <= '0;
            r_stamp     <= STAMP_W'(1);
            r_denied    <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_oldest <= n_oldest;
            r_held   <= n_held;
            r_stamp  <= n_stamp;
            r_denied <= n_denied;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status <= n_status;
            r_s1_hit    <= is_read && read_hit;
            r_s1_count  <= n_held;
            r_s1_denied <= n_denied;
        end
        if (s1_move) begin
            r_out_status <= r_s1_status;
            r_out_count  <= COUNT_W'(r_s1_count);
            r_out_denied <= r_s1_denied;
            if (r_s1_hit) begin
                r_out_payload <= PAYLOAD_W'(mem_rd_data[PAYLOAD_BITS-1:0]);
                r_out_allowed <= mem_rd_data[PAYLOAD_BITS];
                r_out_seq     <= mem_rd_data[DW-1 -: STAMP_W];
            end else begin
                r_out_payload <= '0;
                r_out_allowed <= 1'b0;
                r_out_seq     <= '0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_read_payload  = r_out_payload;
    assign o_read_allowed  = r_out_allowed;
    assign o_read_sequence = r_out_seq;
    assign o_entry_count   = r_out_count;
    assign o_denied_total  = r_out_denied;

    `ASSERT_ALWAYS(a_held_bound, i_clk, i_rst_n, r_held <= CW'(LOG_DEPTH), "entry count beyond log depth")
    `ASSERT_ALWAYS(a_head_only_when_full, i_clk, i_rst_n, (r_oldest == '0) || full, "oldest slot moved before the log filled")
    `ASSERT_NEXT(a_fill_grows, i_clk, i_rst_n, do_append && !full, r_held == $past(r_held) + 1'b1, "append below full did not grow the count")
    `ASSERT_ALWAYS(a_miss_zero, i_clk, i_rst_n, !o_out_valid || (o_status == ST_OK) || ((o_read_payload == '0) && (o_read_sequence == '0) && !o_read_allowed), "failed access returned entry data")

endmodule

### test/overwrite_ring_event_log_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwrite_ring_event_log_tb
// Drives append and read words into the event log and checks every result
// word against a cycle-free predictor of the ring. Starts with a short
// directed sequence (empty log, rejected appends, reads past the count), then
// runs random words through phases of sender gaps and receiver stalls. One
// phase holds off the receiver long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module overwrite_ring_event_log_tb;
    import orel_pkg::*;

typedef struct {
    logic [OPCODE_W-1:0]  opcode;
    logic [PAYLOAD_W-1:0] payload;
    logic                 allowed;
    logic                 action_empty;
    logic [POS_W-1:0]     read_position;
} log_word_t;

typedef struct {
    t_status              status;
    logic [PAYLOAD_W-1:0] read_payload;
    logic                 read_allowed;
    logic [STAMP_W-1:0]   read_sequence;
    logic [COUNT_W-1:0]   entry_count;
    logic [DENIED_W-1:0]  denied_total;
} log_result_t;

class event_log_scoreboard;
    logic [PAYLOAD_W-1:0] payload_mem [DEF_LOG_DEPTH];
    logic                 allowed_mem [DEF_LOG_DEPTH];
    logic [STAMP_W-1:0]   stamp_mem [DEF_LOG_DEPTH];
    logic [POS_W-1:0]     oldest;
    logic [COUNT_W-1:0]   held;
    logic [STAMP_W-1:0]   stamp_next;
    logic [DENIED_W-1:0]  denied;
    log_result_t          expected_q [$];
    int                   failures;

    function new();
        oldest     = '0;
        held       = '0;
        stamp_next = STAMP_W'(1);
        denied     = '0;
        failures   = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Works out the result of one accepted word and updates the ring.
    function void note_word(log_word_t w);
        log_result_t r;
        logic [POS_W-1:0] slot;
        r.status        = ST_OK;
        r.read_payload  = '0;
        r.read_allowed  = 1'b0;
        r.read_sequence = '0;
        if (w.opcode == OP_APPEND) begin
            if (w.action_empty) begin
                r.status = ST_INVALID;
            end else begin
                // The depth is a power of two, so slot arithmetic wraps by itself.
                if (held < DEF_LOG_DEPTH) begin
                    slot = oldest + held[POS_W-1:0];
                    held = held + 1'b1;
                end else begin
                    slot   = oldest;
                    oldest = oldest + 1'b1;
                end
                payload_mem[slot] = w.payload & ({PAYLOAD_W{1'b1}} >> (64 - DEF_PAYLOAD_BITS));
                allowed_mem[slot] = w.allowed;
                stamp_mem[slot]   = stamp_next;
                stamp_next        = stamp_next + 1'b1;
                if (!w.allowed && denied != {DENIED_W{1'b1}})
                    denied = denied + 1'b1;
            end
        end else if (w.read_position >= held) begin
            r.status = ST_NOT_FOUND;
        end else begin
            slot            = oldest + w.read_position;
            r.read_payload  = payload_mem[slot];
            r.read_allowed  = allowed_mem[slot];
            r.read_sequence = stamp_mem[slot];
        end
        r.entry_count  = held;
        r.denied_total = denied;
        expected_q.push_back(r);
    endfunction

    function void check_result(log_result_t got);
        log_result_t want;
        if (expected_q.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("unexpected result word: status %0d count %0d",
                         got.status, got.entry_count);
            return;
        end
        want = expected_q.pop_front();
        if (got.status !== want.status || got.read_payload !== want.read_payload ||
            got.read_allowed !== want.read_allowed ||
            got.read_sequence !== want.read_sequence ||
            got.entry_count !== want.entry_count ||
            got.denied_total !== want.denied_total) begin
            failures++;
            if (failures <= 10) begin
                $display("mismatch (expected/actual): status %0d/%0d payload %h/%h",
                         want.status, got.status, want.read_payload, got.read_payload);
                $display("  allowed %b/%b seq %h/%h count %0d/%0d denied %0d/%0d",
                         want.read_allowed, got.read_allowed,
                         want.read_sequence, got.read_sequence,
                         want.entry_count, got.entry_count,
                         want.denied_total, got.denied_total);
            end
        end
    endfunction
endclass

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [OPCODE_W-1:0]   i_opcode = OP_APPEND;
    logic [PAYLOAD_W-1:0]  i_payload = '0;
    logic                  i_allowed = 1'b0;
    logic                  i_action_empty = 1'b0;
    logic [POS_W-1:0]      i_read_position = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [STATUS_W-1:0]   o_status;
    logic [PAYLOAD_W-1:0]  o_read_payload;
    logic                  o_read_allowed;
    logic [STAMP_W-1:0]    o_read_sequence;
    logic [COUNT_W-1:0]    o_entry_count;
    logic [DENIED_W-1:0]   o_denied_total;

    event_log_scoreboard sb = new();
    log_result_t         seen_result;
    int                  send_idle_pct = 0;
    int                  stall_pct = 0;
    logic                hold_output = 1'b0;
    int                  cycle_count = 0;

    overwrite_ring_event_log dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_payload       (i_payload),
        .i_allowed       (i_allowed),
        .i_action_empty  (i_action_empty),
        .i_read_position (i_read_position),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_read_payload  (o_read_payload),
        .o_read_allowed  (o_read_allowed),
        .o_read_sequence (o_read_sequence),
        .o_entry_count   (o_entry_count),
        .o_denied_total  (o_denied_total)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= hold_output || ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_result.status        = t_status'(o_status);
            seen_result.read_payload  = o_read_payload;
            seen_result.read_allowed  = o_read_allowed;
            seen_result.read_sequence = o_read_sequence;
            seen_result.entry_count   = o_entry_count;
            seen_result.denied_total  = o_denied_total;
            sb.check_result(seen_result);
        end
    end

    function automatic log_word_t make_word(logic [OPCODE_W-1:0] op,
                                            logic [PAYLOAD_W-1:0] payload,
                                            logic allowed, logic empty,
                                            logic [POS_W-1:0] pos);
        log_word_t w;
        w.opcode        = op;
        w.payload       = payload;
        w.allowed       = allowed;
        w.action_empty  = empty;
        w.read_position = pos;
        return w;
    endfunction

    function automatic log_word_t random_word();
        log_word_t w;
        int        pick;
        pick            = $urandom_range(99);
        w.payload       = {$urandom, $urandom};
        w.allowed       = ($urandom_range(99) < 70);
        w.action_empty  = ($urandom_range(99) < 6);
        w.read_position = POS_W'($urandom_range(63));
        if (pick < 55) begin
            w.opcode = OP_APPEND;
            if ($urandom_range(99) < 5)
                w.payload = '0;
            else if ($urandom_range(99) < 5)
                w.payload = '1;
        end else begin
            // Reads mostly land on held entries; the rest take a random position, which may lie past the count.
            w.opcode = OP_READ;
            if (sb.held != 0 && $urandom_range(99) < 85)
                w.read_position = POS_W'($urandom_range(sb.held - 1));
        end
        return w;
    endfunction

    // Entered and left at a falling edge; valid stays high into the next word.
    task automatic send_word(input log_word_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_opcode        <= w.opcode;
        i_payload       <= w.payload;
        i_allowed       <= w.allowed;
        i_action_empty  <= w.action_empty;
        i_read_position <= w.read_position;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_word(w);
        @(negedge i_clk);
    endtask

    task automatic run_phase(input int n_words, input int send_pct, input int recv_pct);
        @(posedge i_clk);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        @(negedge i_clk);
        repeat (n_words) send_word(random_word());
        i_in_valid <= 1'b0;
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty log, rejected appends, ignored fields on reads, reads past the count.
        send_word(make_word(OP_READ, '0, 1'b1, 1'b0, 6'd0));
        send_word(make_word(OP_READ, '1, 1'b0, 1'b1, 6'd63));
        send_word(make_word(OP_APPEND, '1, 1'b0, 1'b1, 6'd0));
        send_word(make_word(OP_APPEND, '1, 1'b1, 1'b0, 6'd63));
        send_word(make_word(OP_APPEND, '0, 1'b0, 1'b0, 6'd0));
        send_word(make_word(OP_APPEND, 64'h8000_0000_0000_0001, 1'b0, 1'b0, 6'd21));
        send_word(make_word(OP_READ, '0, 1'b0, 1'b0, 6'd0));
        send_word(make_word(OP_READ, '1, 1'b0, 1'b1, 6'd1));
        send_word(make_word(OP_READ, '0, 1'b1, 1'b0, 6'd2));
        send_word(make_word(OP_READ, '0, 1'b1, 1'b0, 6'd3));
        send_word(make_word(OP_READ, '0, 1'b1, 1'b0, 6'd63));
        send_word(make_word(OP_APPEND, 64'h5555_5555_5555_5555, 1'b1, 1'b0, 6'd42));
        send_word(make_word(OP_APPEND, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 6'd0));
        send_word(make_word(OP_APPEND, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b1, 6'd0));
        send_word(make_word(OP_READ, '0, 1'b0, 1'b0, 6'd4));
        send_word(make_word(OP_READ, '0, 1'b0, 1'b1, 6'd5));
        i_in_valid <= 1'b0;

        run_phase(320, 0, 0);
        run_phase(320, 82, 0);
        run_phase(320, 0, 82);
        run_phase(320, 37, 37);

        // The receiver holds off while words keep coming, so the block fills up.
        fork
            begin
                @(posedge i_clk);
                hold_output = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_output = 1'b0;
            end
        join_none
        run_phase(300, 0, 0);

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/orel_pkg.sv
sv/orel_ring.sv
sv/overwrite_ring_event_log.sv
test/overwrite_ring_event_log_tb.sv
